### rtl/act_pkg.sv
package act_pkg;

	localparam int CHAR_W = 8;
	localparam int CLS_W  = 3;
	localparam int LINE_W = 16;
	localparam int COL_W  = 12;

	localparam logic [LINE_W-1:0] LINE_LIMIT   = 16'd65535;
	localparam logic [COL_W-1:0]  COLUMN_LIMIT = 12'd4095;

	// token class codes
	localparam logic [CLS_W-1:0] CLS_IGNORED  = 3'd0;
	localparam logic [CLS_W-1:0] CLS_PUNCT    = 3'd1;
	localparam logic [CLS_W-1:0] CLS_OPERATOR = 3'd2;
	localparam logic [CLS_W-1:0] CLS_STRING   = 3'd3;
	localparam logic [CLS_W-1:0] CLS_COMMENT  = 3'd4;
	localparam logic [CLS_W-1:0] CLS_NUMERIC  = 3'd5;
	localparam logic [CLS_W-1:0] CLS_WORD     = 3'd6;
	localparam logic [CLS_W-1:0] CLS_RAW      = 3'd7;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
	localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

	typedef struct packed {
		logic nl;
		logic ign;
		logic pun;
		logic opr;
		logic delim;
		logic quote;
		logic cmt;
		logic digit;
	} char_kind_t;

	typedef struct packed {
		logic [COL_W-1:0]  token_column;
		logic [LINE_W-1:0] token_line;
		logic              prev_closed;
		logic              token_start;
		logic [CLS_W-1:0]  token_class;
		logic [CHAR_W-1:0] out_char;
	} result_t;

endpackage

### rtl/act_classify.sv
module act_classify (
	input  logic [act_pkg::CHAR_W-1:0] ch,
	output act_pkg::char_kind_t        kind
);

	always_comb begin
		kind.nl    = (ch == act_pkg::CH_NL);
		kind.ign   = (ch == act_pkg::CH_NL) || (ch == act_pkg::CH_SPACE);
		kind.pun   = (ch == act_pkg::CH_COMMA) || (ch == act_pkg::CH_COLON) ||
		             (ch == act_pkg::CH_DOT) || (ch == act_pkg::CH_PCT) ||
		             (ch == act_pkg::CH_EQUAL) || (ch == act_pkg::CH_AT) ||
		             (ch == act_pkg::CH_LBRACK) || (ch == act_pkg::CH_RBRACK);
		kind.opr   = (ch == act_pkg::CH_AMP) || (ch == act_pkg::CH_STAR) ||
		             (ch == act_pkg::CH_PLUS) || (ch == act_pkg::CH_MINUS);
		kind.delim = kind.ign || kind.pun || kind.opr;
		kind.quote = (ch == act_pkg::CH_QUOTE);
		kind.cmt   = (ch == act_pkg::CH_HASH) || (ch == act_pkg::CH_SEMI);
		kind.digit = (ch >= act_pkg::CH_ZERO) && (ch <= act_pkg::CH_NINE);
	end

endmodule

### rtl/act_scan.sv
module act_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       eoi,
	input  logic [act_pkg::CHAR_W-1:0] ch,
	input  act_pkg::char_kind_t        kind,
	input  logic                       whole_line,
	input  logic                       res_ready,
	output act_pkg::result_t           res_q,
	output logic                       res_valid_q
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSED,
		ST_STRING,
		ST_COMMENT,
		ST_NUMERIC,
		ST_WORD,
		ST_RAW
	} mode_t;

	mode_t                        mode_q, mode_d;
	logic [act_pkg::LINE_W-1:0]   line_q, start_line_q, start_line_d;
	logic [act_pkg::COL_W-1:0]    column_q, start_col_q, start_col_d, col_inc;
	logic [act_pkg::CLS_W-1:0]    cls;
	logic                         start, closed, done;

	always_comb begin
		mode_d       = mode_q;
		cls          = act_pkg::CLS_IGNORED;
		start        = 1'b0;
		closed       = 1'b0;
		done         = 1'b0;
		start_line_d = start_line_q;
		start_col_d  = start_col_q;
		col_inc      = (column_q < act_pkg::COLUMN_LIMIT) ?
		               column_q + act_pkg::COL_W'(1) : column_q;
		if (whole_line) begin
			if (mode_q != ST_RAW) begin
				closed       = (mode_q != ST_IDLE);
				start        = 1'b1;
				start_line_d = line_q;
				start_col_d  = col_inc;
			end
			cls    = act_pkg::CLS_RAW;
			mode_d = kind.nl ? ST_CLOSED : ST_RAW;
		end else begin
			unique case (mode_q)
				ST_STRING: begin
					cls  = act_pkg::CLS_STRING;
					done = 1'b1;
					if (kind.quote || kind.nl)
						mode_d = ST_CLOSED;
				end
				ST_COMMENT: begin
					if (!kind.nl) begin
						cls  = act_pkg::CLS_COMMENT;
						done = 1'b1;
					end else begin
						closed = 1'b1;
					end
				end
				ST_NUMERIC, ST_WORD: begin
					if (!kind.delim) begin
						cls  = (mode_q == ST_NUMERIC) ? act_pkg::CLS_NUMERIC : act_pkg::CLS_WORD;
						done = 1'b1;
					end else begin
						closed = 1'b1;
					end
				end
				ST_CLOSED, ST_RAW: closed = 1'b1;
				ST_IDLE: ;
				default: ;
			endcase
			if (!done) begin
				mode_d = ST_IDLE;
				if (!kind.ign) begin
					start        = 1'b1;
					start_line_d = line_q;
					start_col_d  = col_inc;
					if (kind.pun) begin
						cls    = act_pkg::CLS_PUNCT;
						mode_d = ST_CLOSED;
					end else if (kind.opr) begin
						cls    = act_pkg::CLS_OPERATOR;
						mode_d = ST_CLOSED;
					end else if (kind.quote) begin
						cls    = act_pkg::CLS_STRING;
						mode_d = ST_STRING;
					end else if (kind.cmt) begin
						cls    = act_pkg::CLS_COMMENT;
						mode_d = ST_COMMENT;
					end else if (kind.digit) begin
						cls    = act_pkg::CLS_NUMERIC;
						mode_d = ST_NUMERIC;
					end else begin
						cls    = act_pkg::CLS_WORD;
						mode_d = ST_WORD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ST_IDLE;
			line_q       <= '0;
			column_q     <= '0;
			start_line_q <= '0;
			start_col_q  <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (step && eoi) begin
				// end of input: back to idle, counters kept
				mode_q <= ST_IDLE;
				if (res_ready)
					res_valid_q <= 1'b0;
			end else if (step) begin
				mode_q       <= mode_d;
				start_line_q <= start_line_d;
				start_col_q  <= start_col_d;
				if (kind.nl) begin
					if (line_q < act_pkg::LINE_LIMIT)
						line_q <= line_q + act_pkg::LINE_W'(1);
					column_q <= '0;
				end else begin
					column_q <= col_inc;
				end
				res_valid_q        <= 1'b1;
				res_q.out_char     <= ch;
				res_q.token_class  <= cls;
				res_q.token_start  <= start;
				res_q.prev_closed  <= closed;
				res_q.token_line   <= (cls == act_pkg::CLS_IGNORED) ? line_q : start_line_d;
				res_q.token_column <= (cls == act_pkg::CLS_IGNORED) ? col_inc : start_col_d;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/assembly_char_tokenizer.sv
// assembly source character tokenizer
// input stream: one source byte per transaction on s_tdata, s_tlast high marks
//   end of input (closes any open token, the byte is ignored, no result comes out)
// output stream: one result per source byte, class on m_tuser, the byte, start and
//   close flags and the token's zero-based start line and one-based start column
//   on m_tdata
// config channel: cfg_data bit 0 selects raw line mode, always ready; write it
//   only while no transaction is in flight
// latency: the byte sits in the input register for one cycle, then classify and
//   scan-state update load the result register at the next edge, so m_tvalid
//   rises one cycle after the input transaction
// throughput: one byte per cycle; the only loop is the scan state and line/column
//   counters, updated in one cycle per byte
// the input register advances whenever the result register is empty or being
//   taken, so a new byte is accepted while a finished result still waits
// stall: with m_tready low the result holds and one more byte is buffered, then
//   s_tready drops
// reset: scan state idle, line and column counters zero, raw line mode off,
//   both stages empty
module assembly_char_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_char
	input  logic        s_tlast,  // end_of_input
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [7:0] out_char, [8] token_start, [9] prev_closed,
	                              // [25:10] token_line, [37:26] token_column, [39:38] zero
	output logic [2:0]  m_tuser,  // [2:0] token_class
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data  // raw_line_mode
);

	logic                        valid_s1;
	logic [act_pkg::CHAR_W-1:0]  char_s1;
	logic                        eoi_s1;
	logic                        whole_line_q;
	logic                        advance;
	act_pkg::char_kind_t         kind;
	act_pkg::result_t            res_q;

	// stage 1 moves into the scan when the result slot is free or draining
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			whole_line_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (cfg_valid)
				whole_line_q <= cfg_data;
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	act_classify u_classify (
		.ch   (char_s1),
		.kind (kind)
	);

	act_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.eoi         (eoi_s1),
		.ch          (char_s1),
		.kind        (kind),
		.whole_line  (whole_line_q),
		.res_ready   (m_tready),
		.res_q       (res_q),
		.res_valid_q (m_tvalid)
	);

	assign m_tuser = res_q.token_class;
	assign m_tdata = {2'b00, res_q.token_column, res_q.token_line,
	                  res_q.prev_closed, res_q.token_start, res_q.out_char};

endmodule

### rtl/act_checker.sv
module act_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input only stalls behind a held result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a held result");

	// start column is one-based
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[37:26] != '0)
		else $error("zero column on result");

	// ignored bytes never start a token
	a_ign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == act_pkg::CLS_IGNORED |-> !m_tdata[8])
		else $error("ignored byte flagged as token start");

	// punctuation and operators are single-byte tokens
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == act_pkg::CLS_PUNCT || m_tuser == act_pkg::CLS_OPERATOR)
		|-> m_tdata[8])
		else $error("single-byte token without start flag");

endmodule

bind assembly_char_tokenizer act_checker u_act_checker (.*);

### bench/tb_assembly_char_tokenizer.sv
`timescale 1ns / 100ps

module tb_assembly_char_tokenizer;

	// scan state of the expected-result tracker, kept apart from the rtl encoding
	typedef enum logic [2:0] {
		SC_IDLE, SC_CLOSED, SC_STRING, SC_COMMENT, SC_NUMERIC, SC_WORD, SC_RAW
	} scan_state_t;

	// receiver stall patterns, switched at random
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_style_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] in_char
	logic        s_tlast;   // end_of_input
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [7:0] out_char, [8] token_start, [9] prev_closed,
	                        // [25:10] token_line, [37:26] token_column, [39:38] zero
	logic [2:0]  m_tuser;   // [2:0] token_class
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;  // raw_line_mode

	assembly_char_tokenizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// expected-result tracker: scan state, counters and raw mode flag
	// ------------------------------------------------------------------
	scan_state_t scan_st    = SC_IDLE;
	int unsigned line_no    = 0;   // zero-based line of the next byte
	int unsigned col_no     = 0;   // one-based column of the last byte on this line
	int unsigned tok_line   = 0;   // where the open token started
	int unsigned tok_col    = 0;
	bit          whole_line = 1'b0;

	act_pkg::result_t pending_results[$];  // expected results, oldest first

	// run statistics and error count
	int mismatches      = 0;
	int chars_sent      = 0;
	int eoi_sent        = 0;
	int results_checked = 0;
	int cfg_writes      = 0;

	function automatic bit is_blank(logic [7:0] c);
		return c == act_pkg::CH_SPACE || c == act_pkg::CH_NL;
	endfunction

	function automatic bit is_punct(logic [7:0] c);
		return c == act_pkg::CH_COMMA || c == act_pkg::CH_COLON || c == act_pkg::CH_DOT ||
		       c == act_pkg::CH_PCT || c == act_pkg::CH_EQUAL || c == act_pkg::CH_AT ||
		       c == act_pkg::CH_LBRACK || c == act_pkg::CH_RBRACK;
	endfunction

	function automatic bit is_oper(logic [7:0] c);
		return c == act_pkg::CH_AMP || c == act_pkg::CH_STAR || c == act_pkg::CH_PLUS ||
		       c == act_pkg::CH_MINUS;
	endfunction

	// a byte that ends a numeric or word token and is then classified afresh
	function automatic bit is_delim(logic [7:0] c);
		return is_blank(c) || is_punct(c) || is_oper(c);
	endfunction

	// advances the tracker by one input transaction; returns 1 with the
	// expected result for a source byte, 0 for an end-of-input marker
	function automatic bit classify_char(input logic [7:0] c, input bit eoi,
	                                     output act_pkg::result_t r);
		scan_state_t               st;
		bit                        done;
		bit                        start;
		bit                        closed;
		logic [act_pkg::CLS_W-1:0] cls;
		int unsigned               own_line;
		int unsigned               own_col;
		st     = scan_st;
		done   = 1'b0;
		start  = 1'b0;
		closed = 1'b0;
		cls    = act_pkg::CLS_IGNORED;
		r      = '0;
		// end of input drops back to idle silently, counters untouched
		if (eoi) begin
			scan_st = SC_IDLE;
			return 1'b0;
		end
		if (col_no < act_pkg::COLUMN_LIMIT)
			col_no++;
		own_col  = col_no;
		own_line = line_no;
		if (whole_line) begin
			// whole line is one token, the newline included
			if (st != SC_RAW) begin
				closed   = (st != SC_IDLE);
				start    = 1'b1;
				tok_line = own_line;
				tok_col  = own_col;
			end
			cls  = act_pkg::CLS_RAW;
			st   = (c == act_pkg::CH_NL) ? SC_CLOSED : SC_RAW;
			done = 1'b1;
		end else begin
			case (st)
				SC_STRING: begin
					// closing quote or newline still belongs to the string
					cls  = act_pkg::CLS_STRING;
					done = 1'b1;
					if (c == act_pkg::CH_QUOTE || c == act_pkg::CH_NL)
						st = SC_CLOSED;
				end
				SC_COMMENT: begin
					// newline ends the comment and is itself ignored
					if (c != act_pkg::CH_NL) begin
						cls  = act_pkg::CLS_COMMENT;
						done = 1'b1;
					end else begin
						closed = 1'b1;
					end
				end
				SC_NUMERIC, SC_WORD: begin
					if (!is_delim(c)) begin
						cls  = (st == SC_NUMERIC) ? act_pkg::CLS_NUMERIC : act_pkg::CLS_WORD;
						done = 1'b1;
					end else begin
						closed = 1'b1;
					end
				end
				SC_CLOSED, SC_RAW: begin
					closed = 1'b1;
				end
				default: begin
				end
			endcase
			if (!done) begin
				st = SC_IDLE;
				if (!is_blank(c)) begin
					start    = 1'b1;
					tok_line = own_line;
					tok_col  = own_col;
					if (is_punct(c)) begin
						cls = act_pkg::CLS_PUNCT;
						st  = SC_CLOSED;
					end else if (is_oper(c)) begin
						cls = act_pkg::CLS_OPERATOR;
						st  = SC_CLOSED;
					end else if (c == act_pkg::CH_QUOTE) begin
						cls = act_pkg::CLS_STRING;
						st  = SC_STRING;
					end else if (c == act_pkg::CH_HASH || c == act_pkg::CH_SEMI) begin
						cls = act_pkg::CLS_COMMENT;
						st  = SC_COMMENT;
					end else if (c >= act_pkg::CH_ZERO && c <= act_pkg::CH_NINE) begin
						cls = act_pkg::CLS_NUMERIC;
						st  = SC_NUMERIC;
					end else begin
						// control bytes and 0xff start a word too
						cls = act_pkg::CLS_WORD;
						st  = SC_WORD;
					end
				end
			end
		end
		scan_st = st;
		// any newline moves to the next line, whatever its class
		if (c == act_pkg::CH_NL) begin
			if (line_no < act_pkg::LINE_LIMIT)
				line_no++;
			col_no = 0;
		end
		r.out_char    = c;
		r.token_class = cls;
		r.token_start = start;
		r.prev_closed = closed;
		// ignored bytes report their own position, everything else the token's
		r.token_line   = act_pkg::LINE_W'((cls == act_pkg::CLS_IGNORED) ? own_line : tok_line);
		r.token_column = act_pkg::COL_W'((cls == act_pkg::CLS_IGNORED) ? own_col : tok_col);
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// sender: bursts of random length with random gaps between them
	// ------------------------------------------------------------------
	bit full_rate   = 1'b0;  // no idling on either side
	int burst_left  = 0;

	task automatic send_item(input logic [7:0] ch, input bit eoi);
		act_pkg::result_t r;
		@(negedge clk);
		if (!full_rate) begin
			if (burst_left == 0) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				                                           : $urandom_range(1, 20);
			end
			burst_left--;
		end
		s_tvalid = 1'b1;
		s_tdata  = ch;
		s_tlast  = eoi;
		// wait for the transaction, then note what it must produce
		do @(posedge clk); while (!s_tready);
		if (classify_char(ch, eoi, r)) begin
			pending_results.push_back(r);
			chars_sent++;
		end else begin
			eoi_sent++;
		end
	endtask

	// stop offering input and let every result come out; end-of-input
	// markers give no result, so the wait runs on to cover the pipeline
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write, only called with the block drained
	task automatic set_whole_line(input bit on);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = on;
		do @(posedge clk); while (!cfg_ready);
		whole_line = on;
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// source text builder for the random part
	// ------------------------------------------------------------------
	logic [7:0] text_q[$];
	string      mnems[6] = '{"mov", "add", "ld", "st", "jmp", "push"};

	task automatic add_str(input string s);
		foreach (s[i])
			text_q.push_back(s[i]);
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_item(s[i], 1'b0);
	endtask

	task automatic add_ident();
		logic [7:0] c;
		int         n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			c = "a";
			if (i > 0 && $urandom_range(0, 3) == 0)
				c = 8'(act_pkg::CH_ZERO + $urandom_range(0, 9));
			else if ($urandom_range(0, 9) == 0)
				c = "_";
			else
				c = 8'(c + $urandom_range(0, 25));
			text_q.push_back(c);
		end
	endtask

	task automatic add_number();
		logic [7:0] c;
		int         n;
		n = $urandom_range(1, 4);
		if ($urandom_range(0, 1)) begin
			// hex letters after the prefix keep the numeric token going
			add_str("0x");
			for (int i = 0; i < n; i++) begin
				c = "a";
				c = ($urandom_range(0, 1)) ? 8'(act_pkg::CH_ZERO + $urandom_range(0, 9))
				                           : 8'(c + $urandom_range(0, 5));
				text_q.push_back(c);
			end
		end else begin
			for (int i = 0; i < n; i++)
				text_q.push_back(8'(act_pkg::CH_ZERO + $urandom_range(0, 9)));
		end
	endtask

	// printable filler; quotes left out inside strings
	task automatic add_free_text(input bit no_quote);
		logic [7:0] c;
		int         n;
		n = $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(32, 126));
			if (no_quote && c == act_pkg::CH_QUOTE)
				c = act_pkg::CH_HASH;
			text_q.push_back(c);
		end
	endtask

	task automatic add_string_lit();
		text_q.push_back(act_pkg::CH_QUOTE);
		add_free_text(1'b1);
		// some strings run to the end of the line unterminated
		if ($urandom_range(0, 4) != 0)
			text_q.push_back(act_pkg::CH_QUOTE);
	endtask

	task automatic add_operand();
		case ($urandom_range(0, 4))
			0: begin
				add_str("r");
				text_q.push_back(8'(act_pkg::CH_ZERO + $urandom_range(0, 9)));
			end
			1: add_number();
			2: begin
				add_str("[");
				add_ident();
				text_q.push_back($urandom_range(0, 1) ? act_pkg::CH_PLUS : act_pkg::CH_MINUS);
				add_number();
				add_str("]");
			end
			3: begin
				if ($urandom_range(0, 1)) begin
					add_str("-");
					add_number();
				end else begin
					add_ident();
					text_q.push_back($urandom_range(0, 1) ? act_pkg::CH_STAR : act_pkg::CH_AMP);
					add_number();
				end
			end
			default: add_string_lit();
		endcase
	endtask

	// one line of assembly-like source, mostly well formed, some noise
	task automatic build_line();
		int n;
		text_q.delete();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				if ($urandom_range(0, 1)) begin
					add_ident();
					add_str(":");
				end
				repeat ($urandom_range(0, 3)) add_str(" ");
				add_str(mnems[$urandom_range(0, 5)]);
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					add_str(i == 0 ? " " : ($urandom_range(0, 1) ? ", " : ","));
					add_operand();
				end
				if ($urandom_range(0, 3) == 0) begin
					add_str(" ");
					text_q.push_back($urandom_range(0, 1) ? act_pkg::CH_SEMI : act_pkg::CH_HASH);
					add_free_text(1'b0);
				end
			end
			6: begin
				text_q.push_back($urandom_range(0, 1) ? act_pkg::CH_SEMI : act_pkg::CH_HASH);
				add_free_text(1'b0);
			end
			7: repeat ($urandom_range(0, 4)) add_str(" ");
			8: begin
				add_str(".ascii ");
				add_string_lit();
			end
			default: begin
				// raw byte noise, every bit pattern possible
				repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		// now and then the line runs on into the next one
		if ($urandom_range(0, 9) != 0)
			text_q.push_back(act_pkg::CH_NL);
	endtask

	// ------------------------------------------------------------------
	// receiver: stall pattern of its own, plus one long hold-off on request
	// ------------------------------------------------------------------
	rx_style_t rx_style        = RX_OPEN;
	int        style_left      = 0;
	int        rx_phase        = 0;
	int        hold_left       = 0;
	int        hold_off_asked  = 0;
	int        hold_off_served = 0;

	always @(negedge clk) begin
		if (hold_off_asked != hold_off_served) begin
			hold_left       = 120;
			hold_off_served = hold_off_asked;
		end
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (full_rate) begin
			m_tready = 1'b1;
		end else begin
			if (style_left == 0) begin
				rx_style   = rx_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			rx_phase++;
			case (rx_style)
				RX_OPEN:    m_tready = 1'b1;
				RX_COIN:    m_tready = 1'($urandom_range(0, 1));
				RX_QUARTER: m_tready = (rx_phase % 4 == 0);
				default:    m_tready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result checker: every output transaction against the oldest expectation
	// ------------------------------------------------------------------
	act_pkg::result_t got;
	act_pkg::result_t want;

	task automatic check_field(input string what, input logic [15:0] exp_v,
	                           input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch on char %02h, expected %0h, actual %0h",
			         $time, what, want.out_char, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.out_char     = m_tdata[7:0];
			got.token_start  = m_tdata[8];
			got.prev_closed  = m_tdata[9];
			got.token_line   = m_tdata[25:10];
			got.token_column = m_tdata[37:26];
			got.token_class  = m_tuser;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual char %02h",
				         $time, got.out_char);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_char", 16'(want.out_char), 16'(got.out_char));
				check_field("token_class", 16'(want.token_class), 16'(got.token_class));
				check_field("token_start", 16'(want.token_start), 16'(got.token_start));
				check_field("prev_closed", 16'(want.prev_closed), 16'(got.prev_closed));
				check_field("token_line", want.token_line, got.token_line);
				check_field("token_column", 16'(want.token_column), 16'(got.token_column));
				check_field("pad bits", 16'd0, 16'(m_tdata[39:38]));
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every class from idle: numeric run on into letters, all punctuation and
	// operators, a string closed by a quote and one closed by a newline, a
	// comment ended by a newline, control byte and 0xff as word bytes, a
	// semicolon swallowed by a word, then end of input mid token
	task automatic test_directed_text();
		send_text("9a ,:.%=@[]&*+-\"s\"\"t\n#c\n");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(act_pkg::CH_SEMI, 1'b0);
		send_item(8'hFF, 1'b1);
		send_text("x\n");
		wait_drained();
	endtask

	// raw lines: newline belongs to the line, empty lines, end of input
	task automatic test_raw_lines();
		set_whole_line(1'b1);
		send_text("mov r1, 2\n\nab\"c");
		send_item(8'h00, 1'b1);
		send_text("x y\n");
		wait_drained();
	endtask

	// register written while a token is still open on either side
	task automatic test_mode_switch();
		send_text("ab");
		wait_drained();
		set_whole_line(1'b0);
		send_text("cd ,\nwor");
		wait_drained();
		set_whole_line(1'b1);
		send_text("d\n\"st");
		wait_drained();
		set_whole_line(1'b0);
		send_text("r\n;c");
		wait_drained();
		set_whole_line(1'b1);
		send_text("e f");
		wait_drained();
		set_whole_line(1'b0);
		send_text("\n");
		wait_drained();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering,
	// so the block fills up and drops s_tready
	task automatic test_backpressure();
		full_rate = 1'b1;
		hold_off_asked++;
		build_line();
		add_str("lbl: add r2, [sp+16] ; spill\n");
		foreach (text_q[i])
			send_item(text_q[i], 1'b0);
		full_rate = 1'b0;
		wait_drained();
	endtask

	// random source in phases, raw mode picked per phase
	task automatic test_random_source();
		int mark;
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			set_whole_line($urandom_range(0, 3) == 0);
			mark = chars_sent;
			while (chars_sent - mark < 110) begin
				build_line();
				foreach (text_q[i])
					send_item(text_q[i], 1'b0);
				if ($urandom_range(0, 11) == 0)
					send_item(8'($urandom_range(0, 255)), 1'b1);
			end
		end
		wait_drained();
		set_whole_line(1'b0);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_text();
		test_raw_lines();
		test_mode_switch();
		test_backpressure();
		test_random_source();

		wait_drained();
		$display("covered %0d source bytes and %0d end-of-input markers, %0d results checked",
		         chars_sent, eoi_sent, results_checked);
		$display("raw line mode written %0d times, mid-token mode switches and a long stall",
		         cfg_writes);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("timeout with %0d results still expected", pending_results.size());
		$display("FAILURE");
		$finish;
	end

endmodule
